// File: design/fsrm_pkg.sv
// ----------------------------------------------------------------------------
// Frame slot ring manager package
// Shared types, constants and helpers for the frame slot ring manager.
// ----------------------------------------------------------------------------
package fsrm_pkg;

  localparam int unsigned SlotCount = 8;
  localparam int unsigned SlotW     = 3;
  localparam int unsigned CountW    = 4;
  localparam int unsigned FrameW    = 32;

  typedef logic [SlotW-1:0]         slot_t;
  typedef logic [CountW-1:0]        count_t;
  typedef logic signed [FrameW-1:0] frame_t;

  localparam frame_t FrameNever = -32'sd7;
  localparam frame_t FrameDone  = -32'sd2;

  typedef enum logic [1:0] {
    KIND_CLAIM_WR = 2'd0,
    KIND_END_WR   = 2'd1,
    KIND_CLAIM_RD = 2'd2,
    KIND_END_RD   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    SLOT_FREE    = 2'd0,
    SLOT_WRITING = 2'd1,
    SLOT_FULL    = 2'd2,
    SLOT_READING = 2'd3
  } slot_state_e;

  typedef enum logic [2:0] {
    ERR_NONE           = 3'd0,
    ERR_OVERFLOW       = 3'd1,
    ERR_EMPTY_MISALIGN = 3'd2,
    ERR_PHANTOM_READ   = 3'd3,
    ERR_UNDERFLOW      = 3'd4,
    ERR_NEXT_FULL      = 3'd5,
    ERR_NEXT_READING   = 3'd6,
    ERR_NEXT_FREE      = 3'd7
  } err_e;

  typedef struct packed {
    slot_t  rd_ptr;
    slot_t  wr_ptr;
    count_t full_cnt;
  } ptr_t;

  typedef struct packed {
    kind_e  kind;
    slot_t  slot;
    frame_t frame;
  } req_t;

  typedef struct packed {
    logic   granted;
    slot_t  slot;
    frame_t frame;
    count_t count;
    err_e   err;
  } rsp_t;

  typedef struct packed {
    logic        en;
    slot_t       addr;
    slot_state_e status;
    logic        frame_en;
    frame_t      frame;
  } slot_wr_t;

  function automatic slot_t next_slot(slot_t s);
    slot_t r;
    if (s == slot_t'(SlotCount - 1)) begin
      r = '0;
    end else begin
      r = s + slot_t'(1);
    end
    return r;
  endfunction

endpackage

// File: design/fsrm_step.sv
// ----------------------------------------------------------------------------
// Frame slot ring step logic
// Decodes one request against the ring state and produces the answer, the
// next pointer state and the single slot table update.
// ----------------------------------------------------------------------------
module fsrm_step (
  input  fsrm_pkg::req_t      req_i,
  input  fsrm_pkg::ptr_t      ptr_i,
  output fsrm_pkg::slot_t     rd_idx_o,
  input  fsrm_pkg::slot_state_e rd_status_i,
  input  fsrm_pkg::frame_t    rd_frame_i,
  output fsrm_pkg::ptr_t      ptr_o,
  output fsrm_pkg::slot_wr_t  wr_o,
  output fsrm_pkg::rsp_t      rsp_o
);

  fsrm_pkg::slot_t  wr_next;
  fsrm_pkg::slot_t  sid_next;
  fsrm_pkg::slot_t  claim_slot;
  logic             ring_full;
  logic             cnt_nonzero;
  logic             sid_bad;
  fsrm_pkg::err_e   rd_err;

  assign wr_next     = fsrm_pkg::next_slot(ptr_i.wr_ptr);
  assign sid_next    = fsrm_pkg::next_slot(req_i.slot);
  assign cnt_nonzero = (ptr_i.full_cnt != '0);
  assign ring_full   = (ptr_i.full_cnt == fsrm_pkg::count_t'(fsrm_pkg::SlotCount)) ||
                       ((wr_next == ptr_i.rd_ptr) && cnt_nonzero);
  assign claim_slot  = (cnt_nonzero || (ptr_i.rd_ptr == wr_next)) ? wr_next : ptr_i.wr_ptr;
  assign sid_bad     = (32'(req_i.slot) >= fsrm_pkg::SlotCount);
  assign rd_err      = ((ptr_i.rd_ptr == ptr_i.wr_ptr) &&
                        (ptr_i.full_cnt > fsrm_pkg::count_t'(1)) &&
                        (ptr_i.full_cnt != fsrm_pkg::count_t'(fsrm_pkg::SlotCount))) ?
                       fsrm_pkg::ERR_PHANTOM_READ : fsrm_pkg::ERR_NONE;

  always_comb begin
    unique case (req_i.kind)
      fsrm_pkg::KIND_CLAIM_WR: rd_idx_o = claim_slot;
      fsrm_pkg::KIND_CLAIM_RD: rd_idx_o = ptr_i.rd_ptr;
      fsrm_pkg::KIND_END_RD:   rd_idx_o = sid_next;
      default:                 rd_idx_o = req_i.slot;
    endcase
  end

  always_comb begin
    ptr_o         = ptr_i;
    wr_o          = '0;
    wr_o.addr     = req_i.slot;
    wr_o.status   = fsrm_pkg::SLOT_FREE;
    rsp_o         = '0;
    rsp_o.err     = fsrm_pkg::ERR_NONE;
    unique case (req_i.kind)
      fsrm_pkg::KIND_CLAIM_WR: begin
        if (ring_full) begin
          rsp_o.err = fsrm_pkg::ERR_NONE;
        end else if ((claim_slot == ptr_i.rd_ptr) && cnt_nonzero) begin
          rsp_o.err = fsrm_pkg::ERR_OVERFLOW;
        end else if (rd_status_i == fsrm_pkg::SLOT_FREE) begin
          wr_o.en       = 1'b1;
          wr_o.addr     = claim_slot;
          wr_o.status   = fsrm_pkg::SLOT_WRITING;
          rsp_o.granted = 1'b1;
          rsp_o.slot    = claim_slot;
          rsp_o.frame   = rd_frame_i;
        end
      end
      fsrm_pkg::KIND_END_WR: begin
        if (sid_bad) begin
          rsp_o.err = fsrm_pkg::ERR_NONE;
        end else if (ptr_i.full_cnt >= fsrm_pkg::count_t'(fsrm_pkg::SlotCount)) begin
          rsp_o.err = fsrm_pkg::ERR_OVERFLOW;
        end else begin
          ptr_o.wr_ptr   = req_i.slot;
          ptr_o.full_cnt = ptr_i.full_cnt + fsrm_pkg::count_t'(1);
          wr_o.en        = 1'b1;
          wr_o.status    = fsrm_pkg::SLOT_FULL;
          wr_o.frame_en  = 1'b1;
          wr_o.frame     = req_i.frame;
          rsp_o.granted  = 1'b1;
          rsp_o.slot     = req_i.slot;
          rsp_o.frame    = req_i.frame;
        end
      end
      fsrm_pkg::KIND_CLAIM_RD: begin
        if (!cnt_nonzero) begin
          rsp_o.err = ((ptr_i.rd_ptr == ptr_i.wr_ptr) || (ptr_i.rd_ptr == wr_next)) ?
                      fsrm_pkg::ERR_NONE : fsrm_pkg::ERR_EMPTY_MISALIGN;
        end else begin
          rsp_o.err = rd_err;
          if (rd_status_i == fsrm_pkg::SLOT_FULL) begin
            wr_o.en       = 1'b1;
            wr_o.addr     = ptr_i.rd_ptr;
            wr_o.status   = fsrm_pkg::SLOT_READING;
            rsp_o.granted = 1'b1;
            rsp_o.slot    = ptr_i.rd_ptr;
            rsp_o.frame   = rd_frame_i;
          end
        end
      end
      fsrm_pkg::KIND_END_RD: begin
        if (sid_bad) begin
          rsp_o.err = fsrm_pkg::ERR_NONE;
        end else if (!cnt_nonzero) begin
          rsp_o.err = fsrm_pkg::ERR_UNDERFLOW;
        end else begin
          ptr_o.rd_ptr = sid_next;
          if (ptr_i.full_cnt == fsrm_pkg::count_t'(1)) begin
            case (rd_status_i)
              fsrm_pkg::SLOT_WRITING: rsp_o.err = fsrm_pkg::ERR_NONE;
              fsrm_pkg::SLOT_FULL:    rsp_o.err = fsrm_pkg::ERR_NEXT_FULL;
              fsrm_pkg::SLOT_READING: rsp_o.err = fsrm_pkg::ERR_NEXT_READING;
              default: begin
                ptr_o.rd_ptr = ptr_i.wr_ptr;
                rsp_o.err    = fsrm_pkg::ERR_NEXT_FREE;
              end
            endcase
          end
          ptr_o.full_cnt = ptr_i.full_cnt - fsrm_pkg::count_t'(1);
          wr_o.en        = 1'b1;
          wr_o.status    = fsrm_pkg::SLOT_FREE;
          wr_o.frame_en  = 1'b1;
          wr_o.frame     = fsrm_pkg::FrameDone;
          rsp_o.granted  = 1'b1;
          rsp_o.slot     = req_i.slot;
          rsp_o.frame    = fsrm_pkg::FrameDone;
        end
      end
      default: begin
        rsp_o.err = fsrm_pkg::ERR_NONE;
      end
    endcase
    rsp_o.count = ptr_o.full_cnt;
  end

endmodule

// File: design/frame_slot_ring_manager.sv
// ----------------------------------------------------------------------------
// Frame slot ring manager
// Claims and releases the slots of a ring shared by one producer and one
// consumer, answering each request with grant or retry.
// ----------------------------------------------------------------------------
//   Channel  Direction  Handshake               Payload
//   request  in         in_valid_i / in_stall_o  kind_i, slot_in_i, frame_in_i
//   answer   out        out_valid_o / out_stall_i granted_o, slot_out_o,
//                                               frame_out_o, item_count_o,
//                                               error_code_o
// A request word is registered, decoded against the ring state, and its
// answer word is registered.
// One word is taken per cycle while the answer side does not stall.
// Reset frees every slot, sets every frame number to minus seven and clears
// the pointers and the count. A stalled answer holds the request register.
module frame_slot_ring_manager (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [1:0]              kind_i,
  input  logic [2:0]              slot_in_i,
  input  logic signed [31:0]      frame_in_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic                    granted_o,
  output logic [2:0]              slot_out_o,
  output logic signed [31:0]      frame_out_o,
  output logic [3:0]              item_count_o,
  output logic [2:0]              error_code_o
);

  logic                   req_valid_q;
  fsrm_pkg::req_t         req_q;
  fsrm_pkg::ptr_t         ptr_q;
  fsrm_pkg::ptr_t         ptr_d;
  fsrm_pkg::slot_state_e  status_q [fsrm_pkg::SlotCount];
  fsrm_pkg::frame_t       frame_q  [fsrm_pkg::SlotCount];
  fsrm_pkg::slot_t        rd_idx;
  fsrm_pkg::slot_wr_t     slot_wr;
  fsrm_pkg::rsp_t         rsp_d;
  fsrm_pkg::rsp_t         rsp_q;
  logic                   out_valid_q;
  logic                   advance;

  assign advance    = req_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = req_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      req_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q.kind  <= fsrm_pkg::kind_e'(kind_i);
      req_q.slot  <= slot_in_i;
      req_q.frame <= frame_in_i;
    end
  end

  fsrm_step u_step (
    .req_i       (req_q),
    .ptr_i       (ptr_q),
    .rd_idx_o    (rd_idx),
    .rd_status_i (status_q[rd_idx]),
    .rd_frame_i  (frame_q[rd_idx]),
    .ptr_o       (ptr_d),
    .wr_o        (slot_wr),
    .rsp_o       (rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q <= '0;
      for (int i = 0; i < fsrm_pkg::SlotCount; i++) begin
        status_q[i] <= fsrm_pkg::SLOT_FREE;
        frame_q[i]  <= fsrm_pkg::FrameNever;
      end
    end else if (advance) begin
      ptr_q <= ptr_d;
      if (slot_wr.en) begin
        status_q[slot_wr.addr] <= slot_wr.status;
        if (slot_wr.frame_en) begin
          frame_q[slot_wr.addr] <= slot_wr.frame;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign granted_o    = rsp_q.granted;
  assign slot_out_o   = rsp_q.slot;
  assign frame_out_o  = rsp_q.frame;
  assign item_count_o = rsp_q.count;
  assign error_code_o = rsp_q.err;

endmodule
